// ----- hw/rtl/rpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants of the page allocator
// Item layouts, operation and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int PAGE_W      = 14;
	localparam int PAGE_SPAN   = 1 << PAGE_W;
	localparam int OUT_COUNT_W = 8;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int FIRST_W     = 14;
	localparam int END_W       = 15;
	localparam int CFG_IDX_W   = 1;

	localparam int DEF_PAGES      = 16384;
	localparam int DEF_COUNT_BITS = 8;

	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_USABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_PAGE     = 1'd1;

	localparam logic [FIRST_W-1:0] FIRST_RESET = 14'd0;
	localparam logic [END_W-1:0]   END_RESET   = 15'd16384;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [PAGE_W-1:0] page_number;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [PAGE_W-1:0]      result_page;
		logic [OUT_COUNT_W-1:0] ref_count;
		logic                   page_released;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// ----- hw/rtl/refcounted_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit: free-list page allocator with reference counts
// Each accepted item is latched and its count read, then its result is registered
// once the output is free; the next item is taken only after that, as the count
// table and stack memories are read then written. A stalled result holds the next
// item off. After reset a clearing pass zeroes all min(PAGES, 16384) entries of the
// count table while no item is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_unit
	import rpa_pkg::*;
#(
	parameter int PAGES      = DEF_PAGES,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [END_W-1:0]     cfg_data
);

	localparam int TBL_DEPTH = (PAGES < PAGE_SPAN) ? PAGES : PAGE_SPAN;
	localparam int TIDX_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int SIDX_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int DEPTH_W   = $clog2(PAGES + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q, state_d;

	logic [FIRST_W-1:0] first_q;
	logic [END_W-1:0]   end_q;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [TIDX_W-1:0]  clr_idx_q;
	cmd_t               item_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;

	logic [COUNT_BITS-1:0] tbl_mem [TBL_DEPTH];
	logic [PAGE_W-1:0]     stk_mem [PAGES];
	logic [COUNT_BITS-1:0] tbl_rd_q;
	logic [PAGE_W-1:0]     stk_rd_q;

	logic [TIDX_W-1:0]     tbl_raddr, tbl_waddr, exec_waddr;
	logic [COUNT_BITS-1:0] tbl_wdata, exec_wdata;
	logic                  tbl_we, exec_tbl_we;
	logic [SIDX_W-1:0]     stk_raddr, stk_waddr;
	logic                  stk_we;

	logic cmd_accept, rsp_free, load_rsp, clr_last;
	logic in_tbl, in_window, empty, full;
	logic inc, dec;
	logic [COUNT_BITS-1:0] cnt_delta, cnt_sum;

	assign cfg_ready  = 1'b1;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_free   = !(rsp_valid_q && rsp_stall);
	assign clr_last   = (clr_idx_q == TIDX_W'(TBL_DEPTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (cmd_accept) state_d = ST_EXEC;
			ST_EXEC:  if (rsp_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_stall = 1'b1;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd_stall = 1'b1;
			ST_IDLE:  cmd_stall = 1'b0;
			ST_EXEC:  load_rsp  = rsp_free;
			default:  cmd_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + TIDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_RESET;
			end_q   <= END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_USABLE: first_q <= cfg_data[FIRST_W-1:0];
				REG_END_PAGE:     end_q   <= cfg_data;
				default:          end_q   <= end_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) item_q <= cmd;
	end

	// hold read addresses on the latched item while it executes
	assign tbl_raddr = (state_q == ST_EXEC) ? TIDX_W'(item_q.page_number)
	                                        : TIDX_W'(cmd.page_number);
	assign stk_raddr = SIDX_W'(depth_q - DEPTH_W'(1));
	assign stk_waddr = SIDX_W'(depth_q);

	always_ff @(posedge clk) begin
		tbl_rd_q <= tbl_mem[tbl_raddr];
		if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_raddr];
		if (stk_we) stk_mem[stk_waddr] <= item_q.page_number;
	end

	assign in_tbl    = (32'(item_q.page_number) < 32'(TBL_DEPTH));
	assign in_window = (item_q.page_number >= first_q) &&
	                   ({1'b0, item_q.page_number} < end_q);
	assign empty     = (depth_q == '0);
	assign full      = (depth_q == DEPTH_W'(PAGES));

	// shared count adder
	assign inc       = (item_q.operation == OP_ADD) && (tbl_rd_q != COUNT_MAX);
	assign dec       = ((item_q.operation == OP_REMOVE) || (item_q.operation == OP_FREE))
	                   && (tbl_rd_q != '0);
	assign cnt_delta = inc ? COUNT_BITS'(1) : (dec ? '1 : '0);
	assign cnt_sum   = tbl_rd_q + cnt_delta;

	always_comb begin
		rsp_d       = '0;
		depth_d     = depth_q;
		exec_tbl_we = 1'b0;
		exec_waddr  = TIDX_W'(item_q.page_number);
		exec_wdata  = cnt_sum;
		stk_we      = 1'b0;
		unique case (item_q.operation) inside
			OP_ALLOC: begin
				if (empty) begin
					rsp_d.status = STATUS_EMPTY;
				end else begin
					depth_d             = depth_q - DEPTH_W'(1);
					exec_tbl_we         = 1'b1;
					exec_waddr          = TIDX_W'(stk_rd_q);
					exec_wdata          = COUNT_BITS'(1);
					rsp_d.result_page   = stk_rd_q;
					rsp_d.ref_count     = OUT_COUNT_W'(1);
				end
			end
			OP_FREE: begin
				if (!in_tbl || !in_window) begin
					rsp_d.status = STATUS_RANGE;
				end else begin
					exec_tbl_we       = 1'b1;
					rsp_d.result_page = item_q.page_number;
					if (cnt_sum != '0) begin
						rsp_d.ref_count = OUT_COUNT_W'(cnt_sum);
					end else if (full) begin
						rsp_d.status = STATUS_FULL;
					end else begin
						stk_we              = 1'b1;
						depth_d             = depth_q + DEPTH_W'(1);
						rsp_d.page_released = 1'b1;
					end
				end
			end
			OP_ADD, OP_REMOVE, OP_QUERY: begin
				if (!in_tbl) begin
					rsp_d.status = STATUS_RANGE;
				end else begin
					exec_tbl_we       = 1'b1;
					rsp_d.result_page = item_q.page_number;
					rsp_d.ref_count   = OUT_COUNT_W'(cnt_sum);
				end
			end
			default: rsp_d = '0;
		endcase
		stk_we = stk_we && load_rsp;
	end

	// clearing pass owns the table write port until done
	always_comb begin
		if (state_q == ST_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_idx_q;
			tbl_wdata = '0;
		end else begin
			tbl_we    = exec_tbl_we && load_rsp;
			tbl_waddr = exec_waddr;
			tbl_wdata = exec_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				depth_q     <= depth_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) rsp_q <= rsp_d;
	end

endmodule
